[sv/msh_pkg.sv]
// ----------------------------------------------------------------------------
// msh_pkg: shared types and constants of the Horner sine pipeline
// Fixed-point widths, saturation limits and the record that travels between
// Horner step stages.
// ----------------------------------------------------------------------------
package msh_pkg;

	localparam int XW = 32;  // |angle|, up to 2^31
	localparam int ZW = 39;  // |z| = round(x^2 / 2^24), up to 2^38
	localparam int EW = 36;  // |z * c_i|, below 2^36
	localparam int RW = 47;  // |r|, below 2^47
	localparam int CW = 30;  // reciprocal coefficient, Q0.32, below 2^30
	localparam int AW = 48;  // rounded product magnitude, up to 2^47

	localparam logic [AW-1:0] ACC_NEG_LIM = 48'h8000_0000_0000;
	localparam logic [AW-1:0] ACC_POS_LIM = 48'h7FFF_FFFF_FFFF;
	localparam logic [AW-1:0] ONE_ACC     = 48'h0001_0000_0000;
	localparam logic [RW-1:0] R_MAX       = 47'h7FFF_FFFF_FFFF;

	// sign-magnitude record carried down the step chain
	typedef struct packed {
		logic          x_neg;
		logic [XW-1:0] x_mag;
		logic [ZW-1:0] z_mag;
		logic [EW-1:0] e_mag;  // magnitude of z*c for the current step (z*c <= 0)
		logic          r_neg;
		logic [RW-1:0] r_mag;
	} pipe_t;

endpackage

[sv/maclaurin_sine_horner_unit.sv]
// ----------------------------------------------------------------------------
// maclaurin_sine_horner_unit: ten-term Maclaurin sine in Horner form
// Throughput: one transaction per cycle while the skid entry is free; every
// Horner step owns its own multipliers and three register stages, so
// nothing is shared or iterated.
// Reset clears all valid bits and the output skid; data registers keep junk.
// ----------------------------------------------------------------------------
module maclaurin_sine_horner_unit #(
	parameter int TERMS = 10
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               s_tvalid,
	output logic               s_tready,
	input  logic signed [31:0] s_tdata,   // [31:0] angle, Q4.28
	output logic               m_tvalid,
	input  logic               m_tready,
	output logic signed [31:0] m_tdata    // [31:0] sine, Q2.30
);
	import msh_pkg::*;

	// Stage map:
	//   s1   |x| and sign
	//   s2   x^2 (32x32)
	//   s3   |z| = round(x^2 / 2^24)
	//   chain TERMS+1 steps of three stages. The first step runs with e = 0,
	//        which yields r = 1 and primes e for i = TERMS.
	//   s4   r * x partial products
	//   s5   round and clamp the product
	//   s6   round to Q2.30 and saturate
	//   then the output register with a one-entry skid behind it.

	logic en;

	logic              vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6;
	logic              x_neg_s1, x_neg_s2, x_neg_s3;
	logic [XW-1:0]     x_mag_s1, x_mag_s2, x_mag_s3;
	logic [63:0]       sq_s2;
	logic [ZW-1:0]     z_mag_s3;

	pipe_t             chain_p [TERMS+2];
	logic              chain_v [TERMS+2];

	logic [XW+31:0]    pr_lo_s4;
	logic [XW+RW-33:0] pr_hi_s4;
	logic              neg_s4, neg_s5;
	logic [AW-1:0]     acc_s5;
	logic [31:0]       sine_s6;

	logic              out_valid_q, skid_valid_q;
	logic [31:0]       sine_q, skid_q;

	logic [64:0]       sq_rnd;
	logic [XW+36:0]    lo_rnd;
	logic [AW+3:0]     acc_full;
	logic [AW-1:0]     lim, acc_nxt;
	logic [AW-1:0]     m_rnd;
	logic [31:0]       m_sat;
	logic [31:0]       sine_nxt;

	// the whole pipeline moves while the skid entry is free
	assign en       = ~skid_valid_q;
	assign s_tready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
		end else if (en) begin
			vld_s1 <= s_tvalid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= chain_v[TERMS+1];
			vld_s5 <= vld_s4;
			vld_s6 <= vld_s5;
		end
	end

	// ---- prologue: z = -x^2, kept as a magnitude ----
	assign sq_rnd = {1'b0, sq_s2} + (65'd1 << 23);

	always_ff @(posedge clk) begin
		if (en) begin
			x_neg_s1 <= s_tdata[31];
			x_mag_s1 <= s_tdata[31] ? (~s_tdata + 32'd1) : s_tdata;
			x_neg_s2 <= x_neg_s1;
			x_mag_s2 <= x_mag_s1;
			sq_s2    <= 64'(x_mag_s1) * 64'(x_mag_s1);
			x_neg_s3 <= x_neg_s2;
			x_mag_s3 <= x_mag_s2;
			z_mag_s3 <= sq_rnd[ZW+23:24];
		end
	end

	// seed: e = 0 and r = 0, so the first step gives r = 1
	always_comb begin
		chain_p[0]       = '0;
		chain_p[0].x_neg = x_neg_s3;
		chain_p[0].x_mag = x_mag_s3;
		chain_p[0].z_mag = z_mag_s3;
		chain_v[0]       = vld_s3;
	end

	// ---- Horner steps ----
	for (genvar k = 0; k <= TERMS; k++) begin : g_step
		msh_step #(
			.NEXT_I (TERMS - k)
		) u_step (
			.clk       (clk),
			.arst_n    (arst_n),
			.en        (en),
			.in_valid  (chain_v[k]),
			.in_pipe   (chain_p[k]),
			.out_valid (chain_v[k+1]),
			.out_pipe  (chain_p[k+1])
		);
	end

	// ---- epilogue: r * (16x), rounded to Q16.32, then to Q2.30 ----
	always_ff @(posedge clk) begin
		if (en) begin
			pr_lo_s4 <= (XW+32)'(chain_p[TERMS+1].r_mag[31:0]) *
				(XW+32)'(chain_p[TERMS+1].x_mag);
			pr_hi_s4 <= (XW+RW-32)'(chain_p[TERMS+1].r_mag[RW-1:32]) *
				(XW+RW-32)'(chain_p[TERMS+1].x_mag);
			neg_s4   <= chain_p[TERMS+1].r_neg ^ chain_p[TERMS+1].x_neg;
		end
	end

	// product times 16: the low partial shifts by 4, the high by 36
	always_comb begin
		lo_rnd   = {1'b0, pr_lo_s4, 4'b0000} + ((XW+37)'(1) << 31);
		acc_full = ((AW+4)'(pr_hi_s4) << 4) + (AW+4)'(lo_rnd[XW+36:32]);
		lim      = neg_s4 ? ACC_NEG_LIM : ACC_POS_LIM;
		acc_nxt  = (acc_full > (AW+4)'(lim)) ? lim : acc_full[AW-1:0];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			acc_s5 <= acc_nxt;
			neg_s5 <= neg_s4;
		end
	end

	// half away from zero on the magnitude, then clamp to the Q2.30 range
	always_comb begin
		m_rnd = acc_s5 + 48'd2;
		if (neg_s5) begin
			m_sat    = (m_rnd[AW-1:2] > 46'h0_8000_0000) ? 32'h8000_0000 : m_rnd[33:2];
			sine_nxt = ~m_sat + 32'd1;
		end else begin
			m_sat    = (m_rnd[AW-1:2] > 46'h0_7FFF_FFFF) ? 32'h7FFF_FFFF : m_rnd[33:2];
			sine_nxt = m_sat;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sine_s6 <= sine_nxt;
		end
	end

	// ---- output register and skid ----
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (!out_valid_q || m_tready) begin
			if (skid_valid_q) begin
				out_valid_q  <= 1'b1;
				skid_valid_q <= 1'b0;
			end else begin
				out_valid_q <= vld_s6;
			end
		end else if (en && vld_s6) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!out_valid_q || m_tready) begin
			sine_q <= skid_valid_q ? skid_q : sine_s6;
		end else if (en && vld_s6) begin
			skid_q <= sine_s6;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = sine_q;

	// ---- checks ----
	// the skid only fills behind a held output
	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> out_valid_q)
		else $error("skid holds a result while the output register is empty");

	a_skid_fill: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(skid_valid_q) |-> $past(out_valid_q && !m_tready))
		else $error("skid filled while the output was free");

	a_skid_drain: assert property (@(posedge clk) disable iff (!arst_n)
		(skid_valid_q && m_tready) |=> (out_valid_q && !skid_valid_q))
		else $error("skid entry not moved to the output when taken");

endmodule

[sv/msh_step.sv]
// ----------------------------------------------------------------------------
// msh_step: one Horner step, three register stages
// r' = 1 + e*r with e = z*c, in sign-magnitude Q16.32, while the next
// step's e = z*c_next is formed alongside.
// ----------------------------------------------------------------------------
module msh_step #(
	parameter int NEXT_I = 1
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           en,
	input  logic           in_valid,
	input  msh_pkg::pipe_t in_pipe,
	output logic           out_valid,
	output msh_pkg::pipe_t out_pipe
);
	import msh_pkg::*;

	// reciprocal of (2i+1)(2i), rounded; zero past the last step
	localparam longint unsigned DEN = (NEXT_I < 1) ? 64'd1 :
		64'((2 * NEXT_I + 1) * (2 * NEXT_I));
	localparam logic [CW-1:0] COEF = (NEXT_I < 1) ? '0 :
		CW'(((64'd1 << 32) + DEN / 2) / DEN);

	logic              vld_s1, vld_s2, vld_s3;
	pipe_t             p_s1, p_s2, p_s3;
	logic [EW+31:0]    pr_lo_s1;
	logic [EW+RW-33:0] pr_hi_s1;
	logic [ZW+CW-1:0]  pz_s1;
	logic [AW-1:0]     acc_s2;
	logic              neg_s2;
	logic [EW-1:0]     e_next_s2;

	logic [EW+32:0]    lo_rnd;
	logic [ZW+CW:0]    pz_rnd;
	logic [AW+3:0]     acc_full;
	logic [AW-1:0]     lim;
	logic [AW-1:0]     acc_nxt;
	logic [AW:0]       sum_pos;
	logic [AW-1:0]     diff_neg, diff_pos;
	pipe_t             p_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_valid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
		end
	end

	// s1: partial products of e*r, and z*c_next
	always_ff @(posedge clk) begin
		if (en) begin
			p_s1     <= in_pipe;
			pr_lo_s1 <= (EW+32)'(in_pipe.e_mag) * (EW+32)'(in_pipe.r_mag[31:0]);
			pr_hi_s1 <= (EW+RW-32)'(in_pipe.e_mag) * (EW+RW-32)'(in_pipe.r_mag[RW-1:32]);
			pz_s1    <= (ZW+CW)'(in_pipe.z_mag) * (ZW+CW)'(COEF);
		end
	end

	// s2: round half away, clamp to the 48-bit limit of the product's sign
	always_comb begin
		lo_rnd   = {1'b0, pr_lo_s1} + ((EW+33)'(1) << 31);
		acc_full = (AW+4)'(pr_hi_s1) + (AW+4)'(lo_rnd[EW+32:32]);
		// e is never positive, so the product is negative unless r is
		lim      = p_s1.r_neg ? ACC_POS_LIM : ACC_NEG_LIM;
		acc_nxt  = (acc_full > (AW+4)'(lim)) ? lim : acc_full[AW-1:0];
		pz_rnd   = {1'b0, pz_s1} + ((ZW+CW+1)'(1) << 31);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			p_s2      <= p_s1;
			acc_s2    <= acc_nxt;
			neg_s2    <= ~p_s1.r_neg;
			e_next_s2 <= pz_rnd[EW+31:32];
		end
	end

	// s3: add one, back to sign-magnitude
	always_comb begin
		sum_pos  = (AW+1)'(acc_s2) + (AW+1)'(ONE_ACC);
		diff_neg = acc_s2 - ONE_ACC;
		diff_pos = ONE_ACC - acc_s2;
		p_nxt       = p_s2;
		p_nxt.e_mag = e_next_s2;
		if (!neg_s2) begin
			p_nxt.r_neg = 1'b0;
			p_nxt.r_mag = (sum_pos > (AW+1)'(R_MAX)) ? R_MAX : sum_pos[RW-1:0];
		end else if (acc_s2 > ONE_ACC) begin
			p_nxt.r_neg = 1'b1;
			p_nxt.r_mag = diff_neg[RW-1:0];
		end else begin
			p_nxt.r_neg = 1'b0;
			p_nxt.r_mag = diff_pos[RW-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			p_s3 <= p_nxt;
		end
	end

	assign out_valid = vld_s3;
	assign out_pipe  = p_s3;

endmodule
